@@ rtl/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types, codes and constants of the temperature statistics monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

    // Item kinds carried in s_tuser
    localparam logic OP_SAMPLE      = 1'b0;
    localparam logic OP_RESET_STATS = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_HIGH = 2'd3;

    // Reset values, hundredths of a degree
    localparam logic signed [15:0] WARN_LEVEL_RST = 16'sd7000;
    localparam logic signed [15:0] CRIT_LEVEL_RST = 16'sd8000;
    localparam logic signed [15:0] VALID_LOW_RST  = -16'sd1000;
    localparam logic signed [15:0] VALID_HIGH_RST = 16'sd12000;
    localparam logic signed [15:0] LOW_MARK_RST   = 16'sd10000;
    localparam logic signed [15:0] HIGH_MARK_RST  = -16'sd10000;

    // Divide by ten: q = (m * RECIP_MUL) >> RECIP_SHIFT, exact for m < 2^22
    localparam int unsigned      RECIP_SHIFT = 23;
    localparam logic [19:0]      RECIP_MUL   = 20'd838861;

    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned M_DATA_W = 136;

    typedef enum logic [1:0] {
        HEALTH_NORMAL = 2'd0,
        HEALTH_WARN   = 2'd1,
        HEALTH_CRIT   = 2'd2
    } health_t;

    typedef struct packed {
        logic signed [15:0] warn_level;
        logic signed [15:0] crit_level;
        logic signed [15:0] valid_low;
        logic signed [15:0] valid_high;
    } cfg_t;

    // Packed so that cur_temp lands in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic               sample_ok;
        health_t            alert_level;
        logic               alert_fire;
        health_t            health;
        logic [COUNT_W-1:0] errors;
        logic [COUNT_W-1:0] reads;
        logic signed [15:0] avg_temp;
        logic signed [15:0] max_temp;
        logic signed [15:0] min_temp;
        logic signed [15:0] cur_temp;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/temp_stats_threshold_monitor.sv @@
// ----------------------------------------------------------------------------
// temp_stats_threshold_monitor
// Temperature min/max/average tracker with two-level latched alarm.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: sample, s_tuser: opcode
//  m_      | out | m_tvalid/m_tready  | m_tdata: result record (136 bits)
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while m_ is not stalled; the result shows on m_ in the cycle after its transaction.
//  Stats state is updated at the accepting edge, so the next item sees it.
//  s_tready drops only while a result sits in the output register unread.
//  cfg_ready is always high. Reset clears state and sets register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module temp_stats_threshold_monitor
    import tsm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [15:0] sample
    input  wire logic [0:0]           s_tuser,   // [0] opcode

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [15:0] cur_temp, [31:16] min_temp, [47:32] max_temp, [63:48] avg_temp,
    // [95:64] reads, [127:96] errors, [129:128] health, [130] alert_fire,
    // [132:131] alert_level, [133] sample_ok, [135:134] zero
    output logic [M_DATA_W-1:0]       m_tdata,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    cfg_t    cfg;
    result_t res_next;
    result_t res_reg;
    logic    m_tvalid_reg;
    logic    accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

    tsm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsm_stats u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .opcode   (s_tuser[0]),
        .sample   (s_tdata),
        .cfg      (cfg),
        .res_next (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsm_cfg.sv @@
// ----------------------------------------------------------------------------
// tsm_cfg
// Threshold and window registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_cfg
    import tsm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warn_level <= WARN_LEVEL_RST;
            cfg_reg.crit_level <= CRIT_LEVEL_RST;
            cfg_reg.valid_low  <= VALID_LOW_RST;
            cfg_reg.valid_high <= VALID_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WARN_LEVEL: cfg_reg.warn_level <= cfg_data;
                REG_CRIT_LEVEL: cfg_reg.crit_level <= cfg_data;
                REG_VALID_LOW:  cfg_reg.valid_low  <= cfg_data;
                REG_VALID_HIGH: cfg_reg.valid_high <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsm_ema.sv @@
// ----------------------------------------------------------------------------
// tsm_ema
// One step of the tenth-weight average: (9*avg + sample)/10, rounded to
// nearest with ties away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_ema
    import tsm_pkg::*;
(
    input  wire logic signed [15:0] avg_in,
    input  wire logic signed [15:0] sample,
    output logic signed [15:0]      avg_out
);

    logic signed [19:0] avg_w;
    logic signed [19:0] num;
    logic [18:0]        mag;
    logic [18:0]        mag_rnd;
    logic [38:0]        prod;
    logic [15:0]        quot;

    always_comb begin
        avg_w   = 20'(avg_in);
        num     = (avg_w <<< 3) + avg_w + 20'(sample);
        // magnitude fits 19 bits: |num| <= 327680
        mag     = num[19] ? 19'(-num) : num[18:0];
        mag_rnd = mag + 19'd5;
        prod    = 39'(mag_rnd) * 39'(RECIP_MUL);
        quot    = prod[RECIP_SHIFT +: 16];
        avg_out = num[19] ? -quot : quot;
    end

endmodule

`default_nettype wire

@@ rtl/tsm_stats.sv @@
// ----------------------------------------------------------------------------
// tsm_stats
// Statistics and alarm state; works out the next state and the result of
// the item on the input port and commits it on accept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_stats
    import tsm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic               opcode,
    input  wire logic signed [15:0] sample,
    input  wire cfg_t               cfg,
    output result_t                 res_next
);

    logic signed [15:0] last_temp_reg,   last_temp_next;
    logic signed [15:0] low_mark_reg,    low_mark_next;
    logic signed [15:0] high_mark_reg,   high_mark_next;
    logic signed [15:0] smooth_temp_reg, smooth_temp_next;
    logic [COUNT_W-1:0] good_count_reg,  good_count_next;
    logic [COUNT_W-1:0] bad_count_reg,   bad_count_next;
    health_t            grade_reg,       grade_next;
    logic               warn_latched_reg, warn_latched_next;
    logic               crit_latched_reg, crit_latched_next;

    logic signed [15:0] ema_avg;
    logic               in_window;
    logic               fire;
    health_t            level;
    logic               ok;

    tsm_ema u_ema (
        .avg_in  (smooth_temp_reg),
        .sample  (sample),
        .avg_out (ema_avg)
    );

    assign in_window = (sample > cfg.valid_low) && (sample < cfg.valid_high);

    always_comb begin
        last_temp_next    = last_temp_reg;
        low_mark_next     = low_mark_reg;
        high_mark_next    = high_mark_reg;
        smooth_temp_next  = smooth_temp_reg;
        good_count_next   = good_count_reg;
        bad_count_next    = bad_count_reg;
        grade_next        = grade_reg;
        warn_latched_next = warn_latched_reg;
        crit_latched_next = crit_latched_reg;
        fire              = 1'b0;
        level             = HEALTH_NORMAL;
        ok                = 1'b0;

        priority if (opcode == OP_RESET_STATS) begin
            low_mark_next     = LOW_MARK_RST;
            high_mark_next    = HIGH_MARK_RST;
            smooth_temp_next  = last_temp_reg;
            good_count_next   = '0;
            warn_latched_next = 1'b0;
            crit_latched_next = 1'b0;
            grade_next        = HEALTH_NORMAL;
        end else if (in_window) begin
            ok             = 1'b1;
            last_temp_next = sample;
            if (!(&good_count_reg)) begin
                good_count_next = good_count_reg + 1'b1;
            end
            // first sample since reset or a stats reset seeds min, max and average
            if (good_count_reg == '0) begin
                low_mark_next    = sample;
                high_mark_next   = sample;
                smooth_temp_next = sample;
            end else begin
                if (sample < low_mark_reg) low_mark_next = sample;
                if (sample > high_mark_reg) high_mark_next = sample;
                smooth_temp_next = ema_avg;
            end

            priority if (sample >= cfg.crit_level) begin
                grade_next = HEALTH_CRIT;
                if (!crit_latched_reg) begin
                    crit_latched_next = 1'b1;
                    fire              = 1'b1;
                    level             = HEALTH_CRIT;
                end
            end else if (sample >= cfg.warn_level) begin
                grade_next = HEALTH_WARN;
                if (!warn_latched_reg) begin
                    warn_latched_next = 1'b1;
                    fire              = 1'b1;
                    level             = HEALTH_WARN;
                end
                crit_latched_next = 1'b0;
            end else begin
                grade_next = HEALTH_NORMAL;
                if (warn_latched_reg || crit_latched_reg) begin
                    warn_latched_next = 1'b0;
                    crit_latched_next = 1'b0;
                    fire              = 1'b1;
                    level             = HEALTH_NORMAL;
                end
            end
        end else begin
            if (!(&bad_count_reg)) begin
                bad_count_next = bad_count_reg + 1'b1;
            end
        end
    end

    always_comb begin
        res_next.pad         = '0;
        res_next.sample_ok   = ok;
        res_next.alert_level = level;
        res_next.alert_fire  = fire;
        res_next.health      = grade_next;
        res_next.errors      = bad_count_next;
        res_next.reads       = good_count_next;
        res_next.avg_temp    = smooth_temp_next;
        res_next.max_temp    = high_mark_next;
        res_next.min_temp    = low_mark_next;
        res_next.cur_temp    = last_temp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_temp_reg    <= '0;
            low_mark_reg     <= LOW_MARK_RST;
            high_mark_reg    <= HIGH_MARK_RST;
            smooth_temp_reg  <= '0;
            good_count_reg   <= '0;
            bad_count_reg    <= '0;
            grade_reg        <= HEALTH_NORMAL;
            warn_latched_reg <= 1'b0;
            crit_latched_reg <= 1'b0;
        end else if (accept) begin
            last_temp_reg    <= last_temp_next;
            low_mark_reg     <= low_mark_next;
            high_mark_reg    <= high_mark_next;
            smooth_temp_reg  <= smooth_temp_next;
            good_count_reg   <= good_count_next;
            bad_count_reg    <= bad_count_next;
            grade_reg        <= grade_next;
            warn_latched_reg <= warn_latched_next;
            crit_latched_reg <= crit_latched_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsm_checker.sv @@
// ----------------------------------------------------------------------------
// tsm_checker
// Port-level checks on the monitor's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata
);

    logic signed [15:0] cur_t;
    logic signed [15:0] min_t;
    logic signed [15:0] max_t;
    logic signed [15:0] avg_t;
    logic [31:0]        reads_t;
    logic [1:0]         health_t_f;
    logic               fire_t;
    logic [1:0]         level_t;
    logic               ok_t;

    assign cur_t      = m_tdata[15:0];
    assign min_t      = m_tdata[31:16];
    assign max_t      = m_tdata[47:32];
    assign avg_t      = m_tdata[63:48];
    assign reads_t    = m_tdata[95:64];
    assign health_t_f = m_tdata[129:128];
    assign fire_t     = m_tdata[130];
    assign level_t    = m_tdata[132:131];
    assign ok_t       = m_tdata[133];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an alert always reports the grade the sample landed in
    a_fire_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fire_t |-> ok_t && (level_t == health_t_f))
        else $error("alert level disagrees with health");

    // accepted sample lies within tracked extremes, and was counted
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ok_t |-> (min_t <= cur_t) && (cur_t <= max_t) && (reads_t != 32'd0))
        else $error("current sample outside min/max");

    // first sample after reset or a stats reset seeds min, max and average
    a_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ok_t && (reads_t == 32'd1) |->
            (min_t == cur_t) && (max_t == cur_t) && (avg_t == cur_t))
        else $error("first sample did not seed statistics");

endmodule

bind temp_stats_threshold_monitor tsm_checker u_tsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
